@@ rtl/tgbl_pkg.sv @@
package tgbl_pkg;
    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int VALUE_BITS = 32;
    localparam int XI_BITS = $clog2(MAX_X);
    localparam int YI_BITS = $clog2(MAX_Y);
    localparam int CELL_BITS = XI_BITS + YI_BITS;
    localparam int CELLS = MAX_X * MAX_Y;
    localparam int CNT_BITS = 7;
    localparam int FRAC_BITS = 16;
    localparam int CELL_W = 4 * VALUE_BITS + 1;

    localparam logic [1:0] FUNC_WR_X = 2'd0;
    localparam logic [1:0] FUNC_WR_Y = 2'd1;
    localparam logic [1:0] FUNC_WR_CELL = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

    // clamp a count register to [2, limit]
    function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] c,
                                                        input logic [CNT_BITS-1:0] lim);
        logic [CNT_BITS-1:0] r;
        r = c;
        if (c < CNT_BITS'(2)) r = CNT_BITS'(2);
        else if (c > lim) r = lim;
        return r;
    endfunction
endpackage

@@ rtl/tgbl_ram.sv @@
module tgbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/tgbl_div.sv @@
// Restoring divider: quo = floor((off << 16) / span) as a 16-bit quotient.
// off < span is guaranteed, so the quotient fits in 16 bits.
module tgbl_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tgbl_pkg::VALUE_BITS:0]    off,
    input  logic [tgbl_pkg::VALUE_BITS:0]    span,
    output logic                             done,
    output logic [tgbl_pkg::FRAC_BITS-1:0]   quo
);
    localparam int W = tgbl_pkg::VALUE_BITS + 2;
    localparam int FB = tgbl_pkg::FRAC_BITS;

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] den_reg, den_next;
    logic [FB-1:0] q_reg, q_next;
    logic [$clog2(FB+1)-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [W-1:0] trial;
    logic [W-1:0] rem_step;
    logic [FB-1:0] q_step;

    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[W-2:0], 1'b0};
        // one restoring step, kept apart so a restart cannot hide the last bit
        if (trial >= den_reg)
        begin
            rem_step = trial - den_reg;
            q_step = {q_reg[FB-2:0], 1'b1};
        end
        else
        begin
            rem_step = trial;
            q_step = {q_reg[FB-2:0], 1'b0};
        end
        if (start)
        begin
            rem_next = W'(off);
            den_next = W'(span);
            q_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            q_next = q_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(FB+1))'(FB - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg <= q_next;
    end

    assign done = busy_reg && (cnt_reg == ($clog2(FB+1))'(FB - 1));
    // span zero gives all ones from the restoring loop; model wants zero
    assign quo = (den_reg == '0) ? '0 : q_step;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !done |-> !start) else $error("divider restarted while busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < ($clog2(FB+1))'(FB)) else $error("divider count overrun");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !busy_reg) else $error("divider stays busy after done");
`endif
endmodule

@@ rtl/terrain_grid_bilinear_lookup.sv @@
// Terrain grid bilinear lookup.
// Input channel (in_valid/in_stall): func selects write x axis entry, write y
// axis entry, write cell (height, three slopes, empty mark) or query point.
// Writes give no result. A query scans the x axis, then the y axis, one entry
// compare per cycle, then runs the 16-step shared divider for each fraction,
// reads the four corner cells one per cycle, and accumulates 16 weighted
// products (one 32x34 multiply per cycle; each corner first forms its weight
// on the same multiplier). One item is in work at a time.
// Output channel (out_valid/out_stall): one result per query is held in an
// output register; the block returns to idle and takes the next item while
// that result waits, but a further query waits for the register to free.
// cfg channel (cfg_valid/cfg_ready) writes x_count (index 0) or y_count
// (index 1); counts clamp to [2, 64]. Reset clears control and sets counts
// to 64; the grid stores are undefined until written.
module terrain_grid_bilinear_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [5:0]  index_x,
    input  logic [5:0]  index_y,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] cell_height,
    input  logic signed [31:0] cell_slope_x,
    input  logic signed [31:0] cell_slope_y,
    input  logic signed [31:0] cell_slope_z,
    input  logic        cell_empty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] height_out,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic        no_data,
    output logic        out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    localparam int VB = tgbl_pkg::VALUE_BITS;
    localparam int XB = tgbl_pkg::XI_BITS;
    localparam int YB = tgbl_pkg::YI_BITS;
    localparam int CB = tgbl_pkg::CELL_BITS;
    localparam int NB = tgbl_pkg::CNT_BITS;
    localparam int FB = tgbl_pkg::FRAC_BITS;
    localparam int CW = tgbl_pkg::CELL_W;
    localparam int AW = 2 * VB + 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_XSCAN = 4'd1;
    localparam logic [3:0] S_YSCAN = 4'd2;
    localparam logic [3:0] S_XDIV  = 4'd3;
    localparam logic [3:0] S_YDIV  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_OOR   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [NB-1:0] xcnt_reg, ycnt_reg;
    logic [NB-1:0] xlim, ylim;

    // ---- stores ----
    logic          ax_we, ay_we, cell_we;
    logic [XB-1:0] ax_ra;
    logic [YB-1:0] ay_ra;
    logic [VB-1:0] ax_rd, ay_rd;
    logic [CB-1:0] cell_ra;
    logic [CW-1:0] cell_rd;

    logic accept;
    assign accept = in_valid && !in_stall;
    assign ax_we = accept && func == tgbl_pkg::FUNC_WR_X;
    assign ay_we = accept && func == tgbl_pkg::FUNC_WR_Y;
    assign cell_we = accept && func == tgbl_pkg::FUNC_WR_CELL;

    tgbl_ram #(.WIDTH(VB), .DEPTH(tgbl_pkg::MAX_X)) u_xaxis (
        .clk(clk), .we(ax_we), .waddr(index_x[XB-1:0]), .wdata(coord_x),
        .raddr(ax_ra), .rdata(ax_rd));
    tgbl_ram #(.WIDTH(VB), .DEPTH(tgbl_pkg::MAX_Y)) u_yaxis (
        .clk(clk), .we(ay_we), .waddr(index_y[YB-1:0]), .wdata(coord_y),
        .raddr(ay_ra), .rdata(ay_rd));
    tgbl_ram #(.WIDTH(CW), .DEPTH(tgbl_pkg::CELLS)) u_cells (
        .clk(clk), .we(cell_we), .waddr({index_x[XB-1:0], index_y[YB-1:0]}),
        .wdata({cell_empty, cell_slope_z, cell_slope_y, cell_slope_x, cell_height}),
        .raddr(cell_ra), .rdata(cell_rd));

    // ---- query registers ----
    logic signed [VB-1:0] qx_reg, qy_reg;
    logic [NB-1:0] idx_reg, idx_next;          // scan index (entry being requested)
    logic signed [VB-1:0] prev_reg;            // previous axis entry
    logic [XB-1:0] bx_reg;
    logic [YB-1:0] by_reg;
    logic [VB:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;   // offset and span, unsigned
    logic found_reg;
    logic [FB-1:0] fx_reg, fy_reg;
    logic [1:0] corner_reg;                    // corner being read / multiplied
    logic [1:0] comp_reg;                      // value component
    logic [CW-1:0] cv_reg [4];
    logic [FB:0] wa, wb;
    logic [2*FB+1:0] w_reg;                    // corner weight Q2.32 (up to 2^32)
    logic wstep_reg;                           // 0: form weight, 1: multiply
    logic signed [AW-1:0] acc_reg [4];
    logic emp_reg;
    logic busy_reg;

    // output register
    logic ov_reg;
    logic signed [VB-1:0] oh_reg, onx_reg, ony_reg, onz_reg;
    logic ond_reg, oor_reg;

    assign xlim = tgbl_pkg::clamp_count(xcnt_reg, NB'(tgbl_pkg::MAX_X));
    assign ylim = tgbl_pkg::clamp_count(ycnt_reg, NB'(tgbl_pkg::MAX_Y));

    // input stalls while busy; a query also waits while the result register is full
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && func == tgbl_pkg::FUNC_QUERY);
    assign cfg_ready = (state_reg == S_IDLE);
    assign busy_reg = (state_reg != S_IDLE);

    // scan read address
    assign ax_ra = (state_reg == S_XSCAN) ? idx_reg[XB-1:0] : bx_reg;
    assign ay_ra = (state_reg == S_YSCAN) ? idx_reg[YB-1:0] : by_reg;
    assign cell_ra = {bx_reg + XB'(corner_reg[0]), by_reg + YB'(corner_reg[1])};

    // compare unit: bracket test on current entry pair
    logic signed [VB-1:0] cur, q;
    logic hit;
    logic [NB-1:0] lim;
    assign cur = (state_reg == S_XSCAN) ? $signed(ax_rd) : $signed(ay_rd);
    assign q = (state_reg == S_XSCAN) ? qx_reg : qy_reg;
    assign lim = (state_reg == S_XSCAN) ? xlim : ylim;
    assign hit = (prev_reg <= q) && (q < cur);

    // divider
    logic div_start, div_done;
    logic [VB:0] div_off, div_span;
    logic [FB-1:0] div_q;
    tgbl_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .off(div_off),
        .span(div_span), .done(div_done), .quo(div_q));

    // weight factor select: corner bit0 picks fx, bit1 picks fy
    assign wa = corner_reg[0] ? {1'b0, fx_reg} : ((FB+1)'(1 << FB) - {1'b0, fx_reg});
    assign wb = corner_reg[1] ? {1'b0, fy_reg} : ((FB+1)'(1 << FB) - {1'b0, fy_reg});

    logic signed [VB-1:0] cval;
    logic signed [AW-1:0] prod;
    always_comb
    begin
        case (comp_reg)
            2'd0: cval = cv_reg[corner_reg][VB-1:0];
            2'd1: cval = cv_reg[corner_reg][2*VB-1:VB];
            2'd2: cval = cv_reg[corner_reg][3*VB-1:2*VB];
            default: cval = cv_reg[corner_reg][4*VB-1:3*VB];
        endcase
    end
    // shared multiplier: weight by 17x17 in step 0, value by weight in step 1
    assign prod = wstep_reg ? (AW'(cval) * $signed({2'b0, w_reg}))
                            : $signed(AW'((2*FB+2)'(wa) * (2*FB+2)'(wb)));

    logic signed [AW-1:0] rnd [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rnd[k] = (acc_reg[k] + (AW'(1) <<< 31)) >>> 32;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        div_start = 1'b0;
        div_off = '0;
        div_span = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && func == tgbl_pkg::FUNC_QUERY)
                begin
                    state_next = S_XSCAN;
                    idx_next = '0;
                end
            end
            S_XSCAN, S_YSCAN:
            begin
                // idx_reg-1 is the entry whose read data is in cur
                idx_next = idx_reg + 1'b1;
                if (idx_reg >= NB'(2) && hit)
                begin
                    if (state_reg == S_XSCAN)
                    begin
                        state_next = S_YSCAN;
                        idx_next = '0;
                    end
                    else
                    begin
                        state_next = S_XDIV;
                        div_start = 1'b1;
                        div_off = xlo_reg;
                        div_span = xhi_reg;
                    end
                end
                else if (idx_reg == lim)
                begin
                    state_next = S_OOR;
                end
            end
            S_XDIV:
            begin
                if (div_done)
                begin
                    state_next = S_YDIV;
                    div_start = 1'b1;
                    div_off = ylo_reg;
                    div_span = yhi_reg;
                end
            end
            S_YDIV:
            begin
                if (div_done) state_next = S_RD;
            end
            S_RD:
            begin
                // corner 3 data is in cell_rd once the index wraps to 0
                if (corner_reg == 2'd0 && found_reg) state_next = S_MUL;
            end
            S_MUL:
            begin
                if (corner_reg == 2'd3 && comp_reg == 2'd3 && wstep_reg)
                    state_next = S_DONE;
            end
            S_DONE, S_OOR:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            xcnt_reg <= NB'(tgbl_pkg::MAX_X);
            ycnt_reg <= NB'(tgbl_pkg::MAX_Y);
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tgbl_pkg::REG_X_COUNT) xcnt_reg <= cfg_data;
                else ycnt_reg <= cfg_data;
            end
            if (state_reg == S_DONE || state_reg == S_OOR) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (state_reg == S_IDLE && accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (state_reg == S_XSCAN || state_reg == S_YSCAN)
        begin
            if (idx_reg != '0) prev_reg <= cur;
            if (state_reg == S_XSCAN && idx_reg >= NB'(2) && hit)
            begin
                bx_reg <= XB'(idx_reg - NB'(2));
                xlo_reg <= {q[VB-1], q} - {prev_reg[VB-1], prev_reg};
                xhi_reg <= {cur[VB-1], cur} - {prev_reg[VB-1], prev_reg};
            end
            if (state_reg == S_YSCAN && idx_reg >= NB'(2) && hit)
            begin
                by_reg <= YB'(idx_reg - NB'(2));
                ylo_reg <= {q[VB-1], q} - {prev_reg[VB-1], prev_reg};
                yhi_reg <= {cur[VB-1], cur} - {prev_reg[VB-1], prev_reg};
                corner_reg <= '0;
                found_reg <= 1'b0;
            end
        end
        if (state_reg == S_XDIV && div_done) fx_reg <= div_q;
        if (state_reg == S_YDIV && div_done) fy_reg <= div_q;
        if (state_reg == S_RD)
        begin
            // address issued for corner_reg; data arrives next cycle
            if (found_reg) cv_reg[corner_reg - 2'd1] <= cell_rd;
            corner_reg <= corner_reg + 2'd1;
            found_reg <= 1'b1;
            if (corner_reg == 2'd0 && found_reg)
            begin
                corner_reg <= '0;
                comp_reg <= '0;
                wstep_reg <= 1'b0;
                for (int k = 0; k < 4; k++) acc_reg[k] <= '0;
            end
        end
        if (state_reg == S_MUL)
        begin
            if (!wstep_reg)
            begin
                w_reg <= prod[2*FB+1:0];
                wstep_reg <= 1'b1;
            end
            else
            begin
                acc_reg[comp_reg] <= acc_reg[comp_reg] + prod;
                comp_reg <= comp_reg + 2'd1;
                if (comp_reg == 2'd3)
                begin
                    corner_reg <= corner_reg + 2'd1;
                    wstep_reg <= 1'b0;
                end
            end
        end
        if (state_reg == S_DONE)
        begin
            oh_reg <= rnd[0][VB-1:0];
            onx_reg <= rnd[1][VB-1:0];
            ony_reg <= rnd[2][VB-1:0];
            onz_reg <= rnd[3][VB-1:0];
            ond_reg <= cv_reg[0][CW-1] | cv_reg[1][CW-1] | cv_reg[2][CW-1] | cv_reg[3][CW-1];
            oor_reg <= 1'b0;
        end
        if (state_reg == S_OOR)
        begin
            oh_reg <= '0;
            onx_reg <= '0;
            ony_reg <= '0;
            onz_reg <= '0;
            ond_reg <= 1'b0;
            oor_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign height_out = oh_reg;
    assign normal_x = onx_reg;
    assign normal_y = ony_reg;
    assign normal_z = onz_reg;
    assign no_data = ond_reg;
    assign out_of_range = oor_reg;

`ifndef ASSERT_OFF
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy_reg) else $error("config taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg) else $error("result dropped while stalled");
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && oor_reg |-> oh_reg == '0 && !ond_reg) else $error("oor result not zero");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XSCAN || state_reg == S_YSCAN) |-> idx_reg <= lim)
        else $error("axis scan past count");
`endif
endmodule

@@ test/terrain_grid_bilinear_lookup_test.sv @@
module terrain_grid_bilinear_lookup_test;

    typedef struct {
        logic [1:0]         fn;
        logic [5:0]         ix;
        logic [5:0]         iy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] h;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic               e;
    } grid_item_t;

    typedef struct {
        logic signed [31:0] h;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               nd;
        logic               oor;
    } terrain_sample_t;

    localparam logic signed [31:0] VMIN = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] func;
    logic [5:0] index_x;
    logic [5:0] index_y;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] cell_height;
    logic signed [31:0] cell_slope_x;
    logic signed [31:0] cell_slope_y;
    logic signed [31:0] cell_slope_z;
    logic cell_empty;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] height_out;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic no_data;
    logic out_of_range;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [6:0] cfg_data;

    terrain_grid_bilinear_lookup dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .index_x(index_x), .index_y(index_y),
        .coord_x(coord_x), .coord_y(coord_y),
        .cell_height(cell_height), .cell_slope_x(cell_slope_x),
        .cell_slope_y(cell_slope_y), .cell_slope_z(cell_slope_z),
        .cell_empty(cell_empty),
        .out_valid(out_valid), .out_stall(out_stall),
        .height_out(height_out), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .no_data(no_data), .out_of_range(out_of_range),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // items waiting to be offered, and samples the block still owes us
    grid_item_t      pending_items[$];
    terrain_sample_t owed_samples[$];
    int              error_count = 0;

    // shadow of the block: counts, axes and cell stores
    logic [6:0]         shadow_xcount;
    logic [6:0]         shadow_ycount;
    logic signed [31:0] shadow_xaxis[tgbl_pkg::MAX_X];
    logic signed [31:0] shadow_yaxis[tgbl_pkg::MAX_Y];
    logic signed [31:0] shadow_h[tgbl_pkg::CELLS];
    logic signed [31:0] shadow_sx[tgbl_pkg::CELLS];
    logic signed [31:0] shadow_sy[tgbl_pkg::CELLS];
    logic signed [31:0] shadow_sz[tgbl_pkg::CELLS];
    logic               shadow_e[tgbl_pkg::CELLS];

    // axes as the stimulus generator last wrote them
    logic signed [31:0] plan_xaxis[tgbl_pkg::MAX_X];
    logic signed [31:0] plan_yaxis[tgbl_pkg::MAX_Y];
    int                 plan_xn;
    int                 plan_yn;

    // pressure controls
    logic sender_hold = 1'b0;
    int   long_hold_asked = 0;
    int   long_hold_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 4_000_000);
        $display("terrain_grid_bilinear_lookup_test failed");
        $finish;
    end

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int clamp_use(input logic [6:0] c, input int lim);
        if (c < 2)
            return 2;
        if (c > lim)
            return lim;
        return int'(c);
    endfunction

    // first bracketing interval, or -1
    function automatic int bracket_x(input logic signed [31:0] q, input int n);
        for (int i = 0; i + 1 < n; i++)
            if (shadow_xaxis[i] <= q && q < shadow_xaxis[i+1])
                return i;
        return -1;
    endfunction

    function automatic int bracket_y(input logic signed [31:0] q, input int n);
        for (int i = 0; i + 1 < n; i++)
            if (shadow_yaxis[i] <= q && q < shadow_yaxis[i+1])
                return i;
        return -1;
    endfunction

    function automatic longint unit_fraction(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi,
                                             input logic signed [31:0] q);
        longint span;
        longint off;
        longint f;
        span = longint'(hi) - longint'(lo);
        off = longint'(q) - longint'(lo);
        if (span == 0)
            return 0;
        f = (off <<< 16) / span;
        return (f > 65535) ? 65535 : f;
    endfunction

    // weighted sum, rounded half up via floor shift
    function automatic logic signed [31:0] weigh(input logic signed [31:0] v0,
            input logic signed [31:0] v1, input logic signed [31:0] v2,
            input logic signed [31:0] v3, input longint w0, input longint w1,
            input longint w2, input longint w3);
        longint s;
        s = longint'(v0) * w0 + longint'(v1) * w1 + longint'(v2) * w2
            + longint'(v3) * w3 + 64'sd2147483648;
        return 32'(s >>> 32);
    endfunction

    // apply one accepted item to the shadow; queries yield a sample
    task automatic apply_item(input grid_item_t it);
        terrain_sample_t smp;
        int bx;
        int by;
        int c00;
        longint fx;
        longint fy;
        longint w0;
        longint w1;
        longint w2;
        longint w3;
        case (it.fn)
            tgbl_pkg::FUNC_WR_X: shadow_xaxis[it.ix] = it.cx;
            tgbl_pkg::FUNC_WR_Y: shadow_yaxis[it.iy] = it.cy;
            tgbl_pkg::FUNC_WR_CELL:
            begin
                c00 = it.ix * tgbl_pkg::MAX_Y + it.iy;
                shadow_h[c00] = it.h;
                shadow_sx[c00] = it.sx;
                shadow_sy[c00] = it.sy;
                shadow_sz[c00] = it.sz;
                shadow_e[c00] = it.e;
            end
            default:
            begin
                smp = '{0, 0, 0, 0, 1'b0, 1'b0};
                bx = bracket_x(it.cx, clamp_use(shadow_xcount, tgbl_pkg::MAX_X));
                by = bracket_y(it.cy, clamp_use(shadow_ycount, tgbl_pkg::MAX_Y));
                if (bx < 0 || by < 0)
                    smp.oor = 1'b1;
                else
                begin
                    fx = unit_fraction(shadow_xaxis[bx], shadow_xaxis[bx+1], it.cx);
                    fy = unit_fraction(shadow_yaxis[by], shadow_yaxis[by+1], it.cy);
                    w0 = (65536 - fx) * (65536 - fy);
                    w1 = fx * (65536 - fy);
                    w2 = (65536 - fx) * fy;
                    w3 = fx * fy;
                    c00 = bx * tgbl_pkg::MAX_Y + by;
                    smp.h = weigh(shadow_h[c00], shadow_h[c00+tgbl_pkg::MAX_Y],
                                  shadow_h[c00+1], shadow_h[c00+tgbl_pkg::MAX_Y+1],
                                  w0, w1, w2, w3);
                    smp.nx = weigh(shadow_sx[c00], shadow_sx[c00+tgbl_pkg::MAX_Y],
                                   shadow_sx[c00+1], shadow_sx[c00+tgbl_pkg::MAX_Y+1],
                                   w0, w1, w2, w3);
                    smp.ny = weigh(shadow_sy[c00], shadow_sy[c00+tgbl_pkg::MAX_Y],
                                   shadow_sy[c00+1], shadow_sy[c00+tgbl_pkg::MAX_Y+1],
                                   w0, w1, w2, w3);
                    smp.nz = weigh(shadow_sz[c00], shadow_sz[c00+tgbl_pkg::MAX_Y],
                                   shadow_sz[c00+1], shadow_sz[c00+tgbl_pkg::MAX_Y+1],
                                   w0, w1, w2, w3);
                    smp.nd = shadow_e[c00] | shadow_e[c00+tgbl_pkg::MAX_Y] | shadow_e[c00+1]
                             | shadow_e[c00+tgbl_pkg::MAX_Y+1];
                end
                owed_samples = {owed_samples, smp};
            end
        endcase
    endtask

    // ---------------- driver: bursts of items, random gaps ----------------
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && !sender_hold)
            begin
                grid_item_t it;
                it = pending_items.pop_front();
                func <= it.fn;
                index_x <= it.ix;
                index_y <= it.iy;
                coord_x <= it.cx;
                coord_y <= it.cy;
                cell_height <= it.h;
                cell_slope_x <= it.sx;
                cell_slope_y <= it.sy;
                cell_slope_z <= it.sz;
                cell_empty <= it.e;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    // odd bursts run without gaps for a while
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- receiver: stall pattern of its own ----------------
    int stall_mode = 0;
    int mode_left = 0;
    int long_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (long_hold_seen != long_hold_asked)
        begin
            // long hold-off so the block fills up and stalls its input
            long_hold_seen <= long_hold_asked;
            long_left <= 1500;
            out_stall <= 1'b1;
        end
        else if (long_left > 0)
        begin
            long_left <= long_left - 1;
            out_stall <= (long_left > 1);
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 400);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= ($urandom_range(0, 49) == 0) ? ~out_stall : out_stall;
            endcase
        end
    end

    // ---------------- monitors ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shadow_xcount = 7'(tgbl_pkg::MAX_X);
            shadow_ycount = 7'(tgbl_pkg::MAX_Y);
        end
        if (rst_n && in_valid && !in_stall)
            apply_item('{func, index_x, index_y, coord_x, coord_y, cell_height,
                         cell_slope_x, cell_slope_y, cell_slope_z, cell_empty});
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == tgbl_pkg::REG_X_COUNT)
                shadow_xcount = cfg_data;
            else
                shadow_ycount = cfg_data;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_samples.size() == 0)
            begin
                $display("unexpected sample at %0t", $realtime);
                error_count++;
            end
            else
            begin
                terrain_sample_t want;
                want = owed_samples.pop_front();
                if (height_out !== want.h)
                    report("height_out", height_out, want.h);
                if (normal_x !== want.nx)
                    report("normal_x", normal_x, want.nx);
                if (normal_y !== want.ny)
                    report("normal_y", normal_y, want.ny);
                if (normal_z !== want.nz)
                    report("normal_z", normal_z, want.nz);
                if (no_data !== want.nd)
                    report("no_data", 32'(no_data), 32'(want.nd));
                if (out_of_range !== want.oor)
                    report("out_of_range", 32'(out_of_range), 32'(want.oor));
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [31:0] rnd32();
        return $urandom;
    endfunction

    function automatic grid_item_t noise_item(input logic [1:0] fn);
        grid_item_t it;
        it = '{fn, 6'($urandom), 6'($urandom), rnd32(), rnd32(), rnd32(), rnd32(),
               rnd32(), rnd32(), 1'($urandom)};
        return it;
    endfunction

    task automatic put_axis_x(input int i, input logic signed [31:0] v);
        grid_item_t it;
        it = noise_item(tgbl_pkg::FUNC_WR_X);
        it.ix = 6'(i);
        it.cx = v;
        plan_xaxis[i] = v;
        pending_items = {pending_items, it};
    endtask

    task automatic put_axis_y(input int i, input logic signed [31:0] v);
        grid_item_t it;
        it = noise_item(tgbl_pkg::FUNC_WR_Y);
        it.iy = 6'(i);
        it.cy = v;
        plan_yaxis[i] = v;
        pending_items = {pending_items, it};
    endtask

    task automatic put_cell(input int i, input int j, input logic signed [31:0] h,
                            input logic signed [31:0] sx, input logic signed [31:0] sy,
                            input logic signed [31:0] sz, input logic e);
        grid_item_t it;
        it = noise_item(tgbl_pkg::FUNC_WR_CELL);
        it.ix = 6'(i);
        it.iy = 6'(j);
        it.h = h;
        it.sx = sx;
        it.sy = sy;
        it.sz = sz;
        it.e = e;
        pending_items = {pending_items, it};
    endtask

    task automatic put_query(input logic signed [31:0] qx, input logic signed [31:0] qy);
        grid_item_t it;
        it = noise_item(tgbl_pkg::FUNC_QUERY);
        it.cx = qx;
        it.cy = qy;
        pending_items = {pending_items, it};
    endtask

    task automatic write_counts(input logic [6:0] xc, input logic [6:0] yc);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= tgbl_pkg::REG_X_COUNT;
        cfg_data <= xc;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= tgbl_pkg::REG_Y_COUNT;
        cfg_data <= yc;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_xn = clamp_use(xc, tgbl_pkg::MAX_X);
        plan_yn = clamp_use(yc, tgbl_pkg::MAX_Y);
    endtask

    // axis values: 0 tight ascending, 1 full-range spread, 2 with repeats,
    // 3 unsorted
    function automatic logic signed [31:0] axis_value(input int style, input int i,
                                                      input int n, inout longint acc);
        longint step;
        case (style)
            0: step = $urandom_range(1, 32'h0003_0000);
            1: step = 64'd4294967295 / (n - 1);
            2: step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32'h0010_0000);
            default: return rnd32();
        endcase
        if (i == 0)
            acc = (style == 1) ? -64'sd2147483648
                               : longint'(rnd32()) / (($urandom_range(0, 1) == 1) ? 2 : 64);
        else
            acc = acc + step;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        return 32'(acc);
    endfunction

    task automatic fill_grid(input int style);
        longint acc;
        acc = 0;
        for (int i = 0; i < plan_xn; i++)
            put_axis_x(i, axis_value(style, i, plan_xn, acc));
        acc = 0;
        for (int j = 0; j < plan_yn; j++)
            put_axis_y(j, axis_value(style, j, plan_yn, acc));
        for (int i = 0; i < plan_xn; i++)
            for (int j = 0; j < plan_yn; j++)
                put_cell(i, j, rnd32(), rnd32(), rnd32(), rnd32(),
                         ($urandom_range(0, 5) == 0));
    endtask

    function automatic logic signed [31:0] pick_x();
        int i;
        longint span;
        i = $urandom_range(0, plan_xn - 2);
        span = longint'(plan_xaxis[i+1]) - longint'(plan_xaxis[i]);
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 1) ? plan_xaxis[i] : rnd32();
        if ($urandom_range(0, 19) == 0)
            return plan_xaxis[plan_xn - 1];
        if (span <= 0)
            return plan_xaxis[i];
        return 32'(longint'(plan_xaxis[i]) + longint'({$urandom, $urandom} % span));
    endfunction

    function automatic logic signed [31:0] pick_y();
        int j;
        longint span;
        j = $urandom_range(0, plan_yn - 2);
        span = longint'(plan_yaxis[j+1]) - longint'(plan_yaxis[j]);
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 1) ? plan_yaxis[j] : rnd32();
        if ($urandom_range(0, 19) == 0)
            return plan_yaxis[plan_yn - 1];
        if (span <= 0)
            return plan_yaxis[j];
        return 32'(longint'(plan_yaxis[j]) + longint'({$urandom, $urandom} % span));
    endfunction

    // mostly queries, with cell rewrites and now and then an axis rewrite
    task automatic random_traffic(input int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                put_cell($urandom_range(0, plan_xn - 1), $urandom_range(0, plan_yn - 1),
                         rnd32(), rnd32(), rnd32(), rnd32(), 1'($urandom));
            else if (r < 14)
                put_axis_x($urandom_range(0, plan_xn - 1), rnd32());
            else if (r < 16)
                put_axis_y($urandom_range(0, plan_yn - 1), rnd32());
            else
                put_query(pick_x(), pick_y());
        end
    endtask

    // wait until the block owes nothing, then let it settle
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || owed_samples.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tgbl_pkg::REG_X_COUNT;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: two-point axes at the value extremes, extreme cells
        write_counts(7'd2, 7'd2);
        put_axis_x(0, VMIN);
        put_axis_x(1, VMAX);
        put_axis_y(0, VMIN);
        put_axis_y(1, VMAX);
        put_cell(0, 0, VMAX, VMAX, VMIN, 32'sd0, 1'b0);
        put_cell(1, 0, VMIN, VMAX, VMIN, 32'sd1, 1'b0);
        put_cell(0, 1, VMAX, VMIN, VMAX, -32'sd1, 1'b0);
        put_cell(1, 1, VMIN, VMIN, VMAX, 32'sd3, 1'b0);
        put_query(VMIN, VMIN);
        put_query(VMAX - 1, VMAX - 1);
        put_query(32'sd0, 32'sd0);
        put_query(VMIN, VMAX - 1);
        put_query(VMAX, 32'sd0);
        put_query(32'sd0, VMAX);
        put_query(32'sd12345, -32'sd77777);
        // empty marks on one corner, then on all of them
        put_cell(1, 1, 32'sd65536, 32'sd1, -32'sd1, 32'sd0, 1'b1);
        put_query(32'sd0, 32'sd0);
        put_query(VMIN, VMIN);
        put_cell(0, 0, VMIN, VMIN, VMIN, VMIN, 1'b1);
        put_cell(1, 0, VMAX, VMAX, VMAX, VMAX, 1'b1);
        put_cell(0, 1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
        put_query(32'sd1, -32'sd1);
        put_query(VMAX - 1, VMIN);
        // equal axis points: nothing brackets
        put_axis_x(1, VMIN);
        put_query(VMIN, 32'sd0);
        drain();

        // counts below the floor clamp to two
        write_counts(7'd0, 7'd1);
        fill_grid(0);
        random_traffic(120);
        drain();

        // counts above the ceiling; long receiver hold-off mid-phase
        write_counts(7'd127, 7'd1);
        fill_grid(1);
        random_traffic(100);
        long_hold_asked = 1;
        drain();

        // full y axis with repeated points; sender pauses while the block drains
        write_counts(7'd1, 7'd64);
        fill_grid(2);
        random_traffic(100);
        while (pending_items.size() > 60)
            @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || owed_samples.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        sender_hold = 1'b0;
        drain();

        write_counts(7'd64, 7'd2);
        fill_grid(0);
        random_traffic(100);
        drain();

        write_counts(7'd5, 7'd7);
        fill_grid(3);
        random_traffic(80);
        drain();

        write_counts(7'd9, 7'd6);
        fill_grid(0);
        random_traffic(100);
        drain();

        if (error_count == 0)
            $display("terrain_grid_bilinear_lookup_test passed");
        else
            $display("terrain_grid_bilinear_lookup_test failed");
        $finish;
    end
endmodule
